/* rtl/afc_pkg.sv */
`default_nettype none

package afc_pkg;

  // Planes tested per box, and planes held in the register file
  localparam int unsigned PLANE_COUNT = 6;
  localparam int unsigned MAX_PLANES  = 6;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Register indexes: planes sit at 0 .. MAX_PLANES-1
  localparam logic [CFG_IDX_W-1:0] REG_SCENE_MASK = CFG_IDX_W'(MAX_PLANES);

  // Field widths
  localparam int unsigned CRD_W    = 16;  // signed Q11.4 coordinate
  localparam int unsigned HALF_W   = 15;  // unsigned Q11.4 half extent
  localparam int unsigned NRM_W    = 16;  // signed Q1.14 normal component
  localparam int unsigned DIST_W   = 16;  // signed Q11.4 distance
  localparam int unsigned FLAGS_W  = 32;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned PLANE_W  = 64;
  localparam int unsigned NRM_FRAC = 14;

  // Internal arithmetic widths
  localparam int unsigned PV_W   = 18;           // positive vertex component
  localparam int unsigned PROD_W = PV_W + NRM_W; // one product term
  localparam int unsigned SUM_W  = PROD_W + 3;   // three terms plus distance

  // Stage enables shared by every plane lane
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } afc_stage_en_t;

endpackage

`default_nettype wire

/* rtl/afc_plane_lane.sv */
`default_nettype none

module afc_plane_lane (
  input  wire                                     clk_i,
  input  wire afc_pkg::afc_stage_en_t             en_i,
  input  wire logic signed [afc_pkg::CRD_W-1:0]   center_x_i,
  input  wire logic signed [afc_pkg::CRD_W-1:0]   center_y_i,
  input  wire logic signed [afc_pkg::CRD_W-1:0]   center_z_i,
  input  wire logic        [afc_pkg::HALF_W-1:0]  half_x_i,
  input  wire logic        [afc_pkg::HALF_W-1:0]  half_y_i,
  input  wire logic        [afc_pkg::HALF_W-1:0]  half_z_i,
  input  wire logic        [afc_pkg::PLANE_W-1:0] plane_i,
  output logic                                    reject_o
);

  logic signed [afc_pkg::NRM_W-1:0]  n_x, n_y, n_z;
  logic signed [afc_pkg::DIST_W-1:0] plane_d;

  logic signed [afc_pkg::PV_W-1:0]   pv_x_d, pv_y_d, pv_z_d;
  logic signed [afc_pkg::PV_W-1:0]   pv_x_q, pv_y_q, pv_z_q;
  logic signed [afc_pkg::PROD_W-1:0] prod_x_d, prod_y_d, prod_z_d;
  logic signed [afc_pkg::PROD_W-1:0] prod_x_q, prod_y_q, prod_z_q;
  logic signed [afc_pkg::SUM_W-1:0]  dist_ext;
  logic signed [afc_pkg::SUM_W-1:0]  sum;
  logic                              reject_d, reject_q;

  // Unpack the plane word
  assign n_x     = plane_i[15:0];
  assign n_y     = plane_i[31:16];
  assign n_z     = plane_i[47:32];
  assign plane_d = plane_i[63:48];

  // Stage 1: positive vertex, half extent takes the sign of the normal
  assign pv_x_d = n_x[afc_pkg::NRM_W-1]
      ? afc_pkg::PV_W'(center_x_i) - $signed(afc_pkg::PV_W'(half_x_i))
      : afc_pkg::PV_W'(center_x_i) + $signed(afc_pkg::PV_W'(half_x_i));
  assign pv_y_d = n_y[afc_pkg::NRM_W-1]
      ? afc_pkg::PV_W'(center_y_i) - $signed(afc_pkg::PV_W'(half_y_i))
      : afc_pkg::PV_W'(center_y_i) + $signed(afc_pkg::PV_W'(half_y_i));
  assign pv_z_d = n_z[afc_pkg::NRM_W-1]
      ? afc_pkg::PV_W'(center_z_i) - $signed(afc_pkg::PV_W'(half_z_i))
      : afc_pkg::PV_W'(center_z_i) + $signed(afc_pkg::PV_W'(half_z_i));

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      pv_x_q <= pv_x_d;
      pv_y_q <= pv_y_d;
      pv_z_q <= pv_z_d;
    end
  end

  // Stage 2: one product per axis
  assign prod_x_d = n_x * pv_x_q;
  assign prod_y_d = n_y * pv_y_q;
  assign prod_z_d = n_z * pv_z_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      prod_z_q <= prod_z_d;
    end
  end

  // Stage 3: reject when dot + d * 2^14 is negative
  assign dist_ext = {{(afc_pkg::SUM_W - afc_pkg::DIST_W - afc_pkg::NRM_FRAC){plane_d[15]}},
                     plane_d, {afc_pkg::NRM_FRAC{1'b0}}};
  assign sum = afc_pkg::SUM_W'(prod_x_q) + afc_pkg::SUM_W'(prod_y_q)
             + afc_pkg::SUM_W'(prod_z_q) + dist_ext;
  assign reject_d = sum[afc_pkg::SUM_W-1];

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      reject_q <= reject_d;
    end
  end

  assign reject_o = reject_q;

endmodule

`default_nettype wire

/* rtl/aabb_frustum_cull.sv */
`default_nettype none

// Box-against-frustum culling pipeline. Each beat carries one axis-aligned box
// (signed Q11.4 center, unsigned Q11.4 half extents, flags, handle, batch-end
// marker) and yields exactly one result beat, in order: visible is 1 when no
// active plane has the box entirely on its negative side and the object flags
// overlap the scene mask. Throughput is one box per clock while the output is
// not stalled, and each box passes through the four register stages
// (positive vertex, products, plane sum, result register). Each stage moves
// whenever the one after it is empty or moving, so a stalled output does not
// block input until all stages are full. Write the plane and mask registers
// only while no box is in flight.
module aabb_frustum_cull (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  // Configuration
  input  wire                                       cfg_we_i,
  input  wire logic [afc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [afc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // Box input
  input  wire                                       in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [afc_pkg::CRD_W-1:0]     center_x_i,
  input  wire logic signed [afc_pkg::CRD_W-1:0]     center_y_i,
  input  wire logic signed [afc_pkg::CRD_W-1:0]     center_z_i,
  input  wire logic        [afc_pkg::HALF_W-1:0]    half_x_i,
  input  wire logic        [afc_pkg::HALF_W-1:0]    half_y_i,
  input  wire logic        [afc_pkg::HALF_W-1:0]    half_z_i,
  input  wire logic        [afc_pkg::FLAGS_W-1:0]   object_flags_i,
  input  wire logic        [afc_pkg::HANDLE_W-1:0]  object_handle_i,
  input  wire                                       last_object_i,
  // Result output
  output logic                                      out_valid_o,
  input  wire                                       out_ready_i,
  output logic                                      visible_o,
  output logic             [afc_pkg::HANDLE_W-1:0]  result_handle_o,
  output logic                                      result_last_o
);

  logic [afc_pkg::PLANE_W-1:0] plane_q [afc_pkg::MAX_PLANES];
  logic [afc_pkg::FLAGS_W-1:0] scene_mask_q;

  afc_pkg::afc_stage_en_t      en;
  logic                        en4;
  logic                        v1_q, v2_q, v3_q, v4_q;

  logic [afc_pkg::HANDLE_W-1:0] handle1_q, handle2_q, handle3_q, handle4_q;
  logic                         last1_q, last2_q, last3_q, last4_q;
  logic                         hit1_q, hit2_q, hit3_q;
  logic                         visible_q;
  logic [afc_pkg::PLANE_COUNT-1:0] reject;

  // Configuration registers; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < afc_pkg::MAX_PLANES; i++) begin
        plane_q[i] <= '0;
      end
      scene_mask_q <= '1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == afc_pkg::REG_SCENE_MASK) begin
        scene_mask_q <= cfg_data_i[afc_pkg::FLAGS_W-1:0];
      end else if (cfg_index_i < afc_pkg::REG_SCENE_MASK) begin
        plane_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  // Stage enables: advance when the stage is empty or the next one advances
  assign en4      = !v4_q || out_ready_i;
  assign en.s3    = !v3_q || en4;
  assign en.s2    = !v2_q || en.s3;
  assign en.s1    = !v1_q || en.s2;
  assign in_ready_o = en.s1;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= in_valid_i;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en4)   v4_q <= v3_q;
    end
  end

  // Carry handle, marker and flag overlap alongside the plane lanes
  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      handle1_q <= object_handle_i;
      last1_q   <= last_object_i;
      hit1_q    <= |(object_flags_i & scene_mask_q);
    end
    if (en.s2) begin
      handle2_q <= handle1_q;
      last2_q   <= last1_q;
      hit2_q    <= hit1_q;
    end
    if (en.s3) begin
      handle3_q <= handle2_q;
      last3_q   <= last2_q;
      hit3_q    <= hit2_q;
    end
    if (en4) begin
      handle4_q <= handle3_q;
      last4_q   <= last3_q;
      visible_q <= hit3_q && !(|reject);
    end
  end

  // One lane per active plane
  for (genvar p = 0; p < afc_pkg::PLANE_COUNT; p++) begin : g_lane
    afc_plane_lane u_lane (
      .clk_i      (clk_i),
      .en_i       (en),
      .center_x_i (center_x_i),
      .center_y_i (center_y_i),
      .center_z_i (center_z_i),
      .half_x_i   (half_x_i),
      .half_y_i   (half_y_i),
      .half_z_i   (half_z_i),
      .plane_i    (plane_q[p]),
      .reject_o   (reject[p])
    );
  end

  assign out_valid_o     = v4_q;
  assign visible_o       = visible_q;
  assign result_handle_o = handle4_q;
  assign result_last_o   = last4_q;

endmodule

`default_nettype wire

/* rtl/aabb_frustum_cull_chk.sv */
`default_nettype none

module aabb_frustum_cull_chk (
  input wire                                 clk_i,
  input wire                                 rst_ni,
  input wire                                 in_valid_i,
  input wire                                 in_ready_o,
  input wire [afc_pkg::HANDLE_W-1:0]         object_handle_i,
  input wire                                 last_object_i,
  input wire                                 out_valid_o,
  input wire                                 out_ready_i,
  input wire [afc_pkg::HANDLE_W-1:0]         result_handle_o,
  input wire                                 result_last_o
);

  // A held result beat stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped under stall");

  // Input is refused only when every stage is full behind a stalled output
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input refused with room in the pipeline");

  // A result appearing on an empty output stems from an accepted input beat
  a_rise_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 4))
    else $error("result beat without matching input beat");

  // That result carries the handle and marker of that input
  a_rise_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> result_handle_o == $past(object_handle_i, 4)
                        && result_last_o == $past(last_object_i, 4))
    else $error("result payload does not match input beat");

endmodule

bind aabb_frustum_cull aabb_frustum_cull_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .object_handle_i (object_handle_i),
  .last_object_i   (last_object_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .result_handle_o (result_handle_o),
  .result_last_o   (result_last_o)
);

`default_nettype wire
